// ===== sv/aluex_pkg.sv =====
// ----------------------------------------------------------------------------
// aluex_pkg
// Types and constants shared by the register ALU execute unit.
// ----------------------------------------------------------------------------
package aluex_pkg;

  localparam logic       CMD_EXEC  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [3:0] CLASS_OPQ = 4'd6;

  localparam logic [3:0] FN_ADD = 4'd0;
  localparam logic [3:0] FN_SUB = 4'd1;
  localparam logic [3:0] FN_AND = 4'd2;
  localparam logic [3:0] FN_XOR = 4'd3;
  localparam logic [3:0] FN_MUL = 4'd4;
  localparam logic [3:0] FN_DIV = 4'd5;
  localparam logic [3:0] FN_MOD = 4'd6;

  localparam logic [5:0] MUL_LAST = 6'd3;
  localparam logic [5:0] DIV_LAST = 6'd63;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  opcode_class;
    logic [3:0]  alu_function;
    logic [3:0]  src_reg;
    logic [3:0]  dest_reg;
    logic [63:0] next_pc;
    logic [63:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] result_value;
    logic        sign_flag;
    logic        zero_flag;
    logic [63:0] pc_value;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_SIMPLE,
    K_MUL,
    K_DIV,
    K_MOD
  } op_kind_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic long_mul;
    logic long_div;
    logic iter_last;
  } dp_status_t;

endpackage

// ===== sv/aluex_ctrl.sv =====
// ----------------------------------------------------------------------------
// aluex_ctrl
// Sequencer for the execute unit: capture, register read, execute,
// multiply or divide iterations, commit; also owns the result valid flag.
// ----------------------------------------------------------------------------
module aluex_ctrl import aluex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_commit;

  assign can_commit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        priority if (status.long_mul) state_nxt = ST_MUL;
        else if (status.long_div)     state_nxt = ST_DIV;
        else                          state_nxt = ST_DONE;
      end
      ST_MUL:  if (status.iter_last) state_nxt = ST_DONE;
      ST_DIV:  if (status.iter_last) state_nxt = ST_DONE;
      ST_DONE: if (can_commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_READ: cmd.read   = 1'b1;
      ST_EXEC: cmd.exec   = 1'b1;
      ST_MUL:  cmd.step   = 1'b1;
      ST_DIV:  cmd.step   = 1'b1;
      ST_DONE: cmd.commit = can_commit;
      default: cmd        = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/aluex_dp.sv =====
// ----------------------------------------------------------------------------
// aluex_dp
// Datapath: register file, program counter, flags, combinational ALU,
// shared 32x32 multiplier (three partial products) and a restoring
// divider giving one quotient bit per cycle; result register.
// ----------------------------------------------------------------------------
module aluex_dp import aluex_pkg::*; #(
  parameter int NUM_REGS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output out_item_t  out_item
);

  localparam int IDX_W = $clog2(NUM_REGS);

  function automatic logic [IDX_W-1:0] reg_idx(input logic [3:0] f);
    logic [4:0] w;
    w = {1'b0, f};
    if (w >= 5'(NUM_REGS)) w = w - 5'(NUM_REGS);
    return w[IDX_W-1:0];
  endfunction

  in_item_t          item_r;
  logic [63:0]       rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;
  logic [63:0]       a_raw_r, b_raw_r;
  logic              a_vld_r, b_vld_r;
  logic [63:0]       a_op, b_op;
  logic [IDX_W-1:0]  ra_idx, rb_idx;

  logic [63:0]       pc_r;
  logic              sign_r, zero_r;

  logic              is_load, fn_ok, op_valid, wr_en;
  logic [63:0]       simple_res;
  op_kind_t          kind_r;
  logic [63:0]       res_r;
  logic [5:0]        cnt_r;

  logic [31:0]       mx, my;
  logic [63:0]       prod_r, acc_r;

  logic [63:0]       rem_r, quo_r;
  logic [64:0]       trial;
  logic [65:0]       diff;

  logic [63:0]       res_final;
  logic              sign_new, zero_new;
  out_item_t         out_r;

  assign ra_idx = reg_idx(item_r.src_reg);
  assign rb_idx = reg_idx(item_r.dest_reg);
  assign a_op   = a_vld_r ? a_raw_r : '0;
  assign b_op   = b_vld_r ? b_raw_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
  end

  // register file
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      a_raw_r <= rf_mem[ra_idx];
      b_raw_r <= rf_mem[rb_idx];
      a_vld_r <= rf_vld_r[ra_idx];
      b_vld_r <= rf_vld_r[rb_idx];
    end
    if (cmd.commit && wr_en) rf_mem[rb_idx] <= res_final;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (cmd.commit && wr_en) begin
      rf_vld_r[rb_idx] <= 1'b1;
    end
  end

  // decode
  assign is_load  = (item_r.cmd == CMD_WRITE);
  assign fn_ok    = (item_r.alu_function == FN_ADD) || (item_r.alu_function == FN_SUB) ||
                    (item_r.alu_function == FN_AND) || (item_r.alu_function == FN_XOR) ||
                    (item_r.alu_function == FN_MUL) || (item_r.alu_function == FN_DIV) ||
                    (item_r.alu_function == FN_MOD);
  assign op_valid = !is_load && (item_r.opcode_class == CLASS_OPQ) && fn_ok;
  assign wr_en    = is_load || op_valid;

  assign status.long_mul  = op_valid && (item_r.alu_function == FN_MUL);
  assign status.long_div  = op_valid && (a_op != '0) &&
                            ((item_r.alu_function == FN_DIV) ||
                             (item_r.alu_function == FN_MOD));
  assign status.iter_last = (kind_r == K_MUL) ? (cnt_r == MUL_LAST) : (cnt_r == DIV_LAST);

  always_comb begin
    simple_res = b_op;
    if (is_load) begin
      simple_res = item_r.load_value;
    end else if (op_valid) begin
      unique case (item_r.alu_function)
        FN_ADD:  simple_res = b_op + a_op;
        FN_SUB:  simple_res = b_op - a_op;
        FN_AND:  simple_res = b_op & a_op;
        FN_XOR:  simple_res = b_op ^ a_op;
        FN_DIV:  simple_res = '1;
        default: simple_res = b_op;
      endcase
    end
  end

  // multiplier operand select: aL*bL, aL*bH, aH*bL
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: begin mx = a_op[31:0];  my = b_op[31:0];  end
      2'd1: begin mx = a_op[31:0];  my = b_op[63:32]; end
      2'd2: begin mx = a_op[63:32]; my = b_op[31:0];  end
      default: begin mx = '0; my = '0; end
    endcase
  end

  assign trial = {rem_r, quo_r[63]};
  assign diff  = {1'b0, trial} - {2'b00, a_op};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= simple_res;
      cnt_r <= '0;
      acc_r <= '0;
      rem_r <= '0;
      quo_r <= b_op;
      priority if (status.long_mul) kind_r <= K_MUL;
      else if (status.long_div && (item_r.alu_function == FN_DIV)) kind_r <= K_DIV;
      else if (status.long_div) kind_r <= K_MOD;
      else kind_r <= K_SIMPLE;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 6'd1;
      if (kind_r == K_MUL) begin
        prod_r <= mx * my;
        if (cnt_r != '0) begin
          acc_r <= acc_r + ((cnt_r >= 6'd2) ? {prod_r[31:0], 32'b0} : prod_r);
        end
      end else if (!diff[65]) begin
        rem_r <= diff[63:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= trial[63:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

  always_comb begin
    unique case (kind_r)
      K_MUL:   res_final = acc_r;
      K_DIV:   res_final = quo_r;
      K_MOD:   res_final = rem_r;
      default: res_final = res_r;
    endcase
  end

  assign sign_new = is_load ? sign_r : (op_valid && res_final[63]);
  assign zero_new = is_load ? zero_r : (op_valid && (res_final == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      sign_r <= 1'b0;
      zero_r <= 1'b0;
    end else if (cmd.commit) begin
      if (op_valid) pc_r <= item_r.next_pc;
      sign_r <= sign_new;
      zero_r <= zero_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.ok           <= wr_en;
      out_r.result_value <= wr_en ? res_final : b_op;
      out_r.sign_flag    <= sign_new;
      out_r.zero_flag    <= zero_new;
      out_r.pc_value     <= op_valid ? item_r.next_pc : pc_r;
    end
  end

  assign out_item = out_r;

endmodule

// ===== sv/alu_register_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// alu_register_execute_unit_top
// Register-to-register ALU execute unit with a 64-bit register file.
// ----------------------------------------------------------------------------
// Add/sub/and/xor, register writes, invalid items and div/mod by zero use the
//   combinational ALU; mul steps through three partial products and div/mod
//   by a non-zero value through the 64-step divider; one item at a time.
// Output register lets the next item be accepted while a result waits.
// Reset: synchronous, active low; register file, PC and flags read as zero.
// ----------------------------------------------------------------------------
module alu_register_execute_unit_top import aluex_pkg::*; #(
  parameter int NUM_REGS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  aluex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  aluex_dp #(
    .NUM_REGS (NUM_REGS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the register ALU execute unit.
// A directed table covers wrap-around, borrow, the full-width multiply,
// divide and modulo by zero, rejected class and function codes and register
// preloads. It is followed by about 900 random items. Random loads keep
// operands varied, and most executes are well formed. A local model of the
// register file, PC and flags predicts each result the table does not fix,
// and the results are compared field by field in order. Idling runs in three
// phases: the sender idles lightly while the receiver stalls heavily, then the
// reverse, then neither idles.
// ----------------------------------------------------------------------------
module tb;
  import aluex_pkg::*;

  localparam int NUM_REGS = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP = 64'h8000_0000_0000_0000;

  typedef struct {
    in_item_t  item;
    logic      fixed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  logic [63:0] reg_model [NUM_REGS];
  logic [63:0] pc_model;
  logic        sign_model;
  logic        zero_model;

  out_item_t   expected_results [$];
  row_t        directed_rows [25];
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 82;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          write_count = 0;
  int          reject_count = 0;
  int          op_count [7];
  int          idle_cycles = 0;

  alu_register_execute_unit_top #(.NUM_REGS(NUM_REGS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t exec_item(logic [3:0] cls, logic [3:0] fn, logic [3:0] ra,
                                         logic [3:0] rb, logic [63:0] npc);
    in_item_t it;
    it = '0;
    it.cmd = CMD_EXEC;
    it.opcode_class = cls;
    it.alu_function = fn;
    it.src_reg = ra;
    it.dest_reg = rb;
    it.next_pc = npc;
    it.load_value = ~npc;
    return it;
  endfunction

  // unused fields are set so that a write picking them up shows
  function automatic in_item_t write_item(logic [3:0] rb, logic [63:0] value);
    in_item_t it;
    it = '0;
    it.cmd = CMD_WRITE;
    it.opcode_class = CLASS_OPQ;
    it.alu_function = FN_DIV;
    it.src_reg = ~rb;
    it.dest_reg = rb;
    it.next_pc = ONES;
    it.load_value = value;
    return it;
  endfunction

  function automatic out_item_t result_of(logic ok, logic [63:0] value, logic sign,
                                          logic zero, logic [63:0] pc);
    out_item_t r;
    r.ok = ok;
    r.result_value = value;
    r.sign_flag = sign;
    r.zero_flag = zero;
    r.pc_value = pc;
    return r;
  endfunction

  function automatic out_item_t apply_instruction(in_item_t it);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    logic        valid;
    int unsigned ra;
    int unsigned rb;
    out_item_t   res;
    ra = it.src_reg % NUM_REGS;
    rb = it.dest_reg % NUM_REGS;
    res.ok = 1'b1;
    if (it.cmd == CMD_WRITE) begin
      reg_model[rb] = it.load_value;
      write_count++;
    end else begin
      a = reg_model[ra];
      b = reg_model[rb];
      r = '0;
      valid = (it.opcode_class == CLASS_OPQ);
      sign_model = 1'b0;
      zero_model = 1'b0;
      if (valid) begin
        case (it.alu_function)
          FN_ADD: r = b + a;
          FN_SUB: r = b - a;
          FN_AND: r = b & a;
          FN_XOR: r = b ^ a;
          FN_MUL: r = b * a;
          FN_DIV: r = (a == 64'd0) ? ONES : b / a;
          FN_MOD: r = (a == 64'd0) ? b : b % a;
          default: valid = 1'b0;
        endcase
      end
      if (valid) begin
        reg_model[rb] = r;
        pc_model = it.next_pc;
        sign_model = r[63];
        zero_model = (r == 64'd0);
        op_count[it.alu_function]++;
      end else begin
        res.ok = 1'b0;
        reject_count++;
      end
    end
    res.result_value = reg_model[rb];
    res.sign_flag = sign_model;
    res.zero_flag = zero_model;
    res.pc_value = pc_model;
    return res;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.cmd = ($urandom_range(99) < 28) ? CMD_WRITE : CMD_EXEC;
    it.opcode_class = ($urandom_range(99) < 85) ? CLASS_OPQ : 4'($urandom_range(15));
    it.alu_function = ($urandom_range(99) < 90) ? 4'($urandom_range(6)) : 4'($urandom_range(15));
    it.src_reg = 4'($urandom_range(15));
    it.dest_reg = 4'($urandom_range(15));
    it.next_pc = {$urandom, $urandom};
    case ($urandom_range(9))
      0: it.load_value = 64'd0;
      1: it.load_value = ONES;
      2, 3: it.load_value = 64'($urandom_range(20));
      4: it.load_value = TOP | 64'($urandom_range(255));
      5: it.load_value = 64'($urandom) << $urandom_range(32);
      default: it.load_value = {$urandom, $urandom};
    endcase
    return it;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] result %0d: %s got %h, expected %h", $time, results_checked, field, got,
             want);
    mismatch_count++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected item, result_value", got.result_value, '0);
      return;
    end
    want = expected_results.pop_front();
    if (got.ok !== want.ok) report_mismatch("ok", 64'(got.ok), 64'(want.ok));
    if (got.result_value !== want.result_value)
      report_mismatch("result_value", got.result_value, want.result_value);
    if (got.sign_flag !== want.sign_flag)
      report_mismatch("sign_flag", 64'(got.sign_flag), 64'(want.sign_flag));
    if (got.zero_flag !== want.zero_flag)
      report_mismatch("zero_flag", 64'(got.zero_flag), 64'(want.zero_flag));
    if (got.pc_value !== want.pc_value) report_mismatch("pc_value", got.pc_value, want.pc_value);
    results_checked++;
  endtask

  task automatic push_item(in_item_t it, logic fixed, out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_instruction(it);
    expected_results.push_back(fixed ? want : predicted);
    items_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_item);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without an item moving", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_REGS; i++) reg_model[i] = '0;
    for (int i = 0; i < 7; i++) op_count[i] = 0;
    pc_model = '0;
    sign_model = 1'b0;
    zero_model = 1'b0;

    directed_rows[ 0] = '{exec_item(CLASS_OPQ, FN_ADD, 0, 0, 64'h100), 1'b1,
                          result_of(1, 64'd0, 0, 1, 64'h100)};
    directed_rows[ 1] = '{write_item(1, ONES), 1'b1, result_of(1, ONES, 0, 1, 64'h100)};
    directed_rows[ 2] = '{write_item(2, 64'd1), 1'b1, result_of(1, 64'd1, 0, 1, 64'h100)};
    directed_rows[ 3] = '{write_item(3, TOP), 1'b1, result_of(1, TOP, 0, 1, 64'h100)};
    directed_rows[ 4] = '{exec_item(CLASS_OPQ, FN_ADD, 2, 1, 64'h108), 1'b1,
                          result_of(1, 64'd0, 0, 1, 64'h108)};
    directed_rows[ 5] = '{write_item(1, ONES), 1'b1, result_of(1, ONES, 0, 1, 64'h108)};
    directed_rows[ 6] = '{exec_item(CLASS_OPQ, FN_SUB, 2, 4, 64'h110), 1'b1,
                          result_of(1, ONES, 1, 0, 64'h110)};
    directed_rows[ 7] = '{exec_item(CLASS_OPQ, FN_AND, 3, 1, ONES), 1'b1,
                          result_of(1, TOP, 1, 0, ONES)};
    directed_rows[ 8] = '{exec_item(CLASS_OPQ, FN_XOR, 1, 1, 64'h0), 1'b1,
                          result_of(1, 64'd0, 0, 1, 64'h0)};
    directed_rows[ 9] = '{exec_item(CLASS_OPQ, FN_MUL, 4, 4, 64'h118), 1'b1,
                          result_of(1, 64'd1, 0, 0, 64'h118)};
    directed_rows[10] = '{exec_item(CLASS_OPQ, FN_MUL, 3, 3, 64'h120), 1'b1,
                          result_of(1, 64'd0, 0, 1, 64'h120)};
    directed_rows[11] = '{write_item(5, ONES), 1'b1, result_of(1, ONES, 0, 1, 64'h120)};
    directed_rows[12] = '{exec_item(CLASS_OPQ, FN_DIV, 2, 5, 64'h128), 1'b1,
                          result_of(1, ONES, 1, 0, 64'h128)};
    directed_rows[13] = '{write_item(6, 64'd1000), 1'b0, '0};
    directed_rows[14] = '{write_item(7, 64'd7), 1'b0, '0};
    directed_rows[15] = '{exec_item(CLASS_OPQ, FN_DIV, 7, 6, 64'h130), 1'b0, '0};
    directed_rows[16] = '{exec_item(CLASS_OPQ, FN_MOD, 7, 6, 64'h138), 1'b0, '0};
    // divide by zero
    directed_rows[17] = '{exec_item(CLASS_OPQ, FN_DIV, 0, 6, 64'h140), 1'b1,
                          result_of(1, ONES, 1, 0, 64'h140)};
    directed_rows[18] = '{write_item(8, 64'h55), 1'b1, result_of(1, 64'h55, 1, 0, 64'h140)};
    // modulo by zero keeps the dividend
    directed_rows[19] = '{exec_item(CLASS_OPQ, FN_MOD, 0, 8, 64'h148), 1'b1,
                          result_of(1, 64'h55, 0, 0, 64'h148)};
    // rejected class or function: flags cleared, PC and register kept
    directed_rows[20] = '{exec_item(4'hF, FN_ADD, 2, 8, 64'h150), 1'b1,
                          result_of(0, 64'h55, 0, 0, 64'h148)};
    directed_rows[21] = '{exec_item(CLASS_OPQ, 4'd7, 2, 8, 64'h158), 1'b1,
                          result_of(0, 64'h55, 0, 0, 64'h148)};
    directed_rows[22] = '{exec_item(CLASS_OPQ, 4'hF, 2, 8, 64'h160), 1'b1,
                          result_of(0, 64'h55, 0, 0, 64'h148)};
    directed_rows[23] = '{exec_item(4'h0, FN_MUL, 2, 8, 64'h168), 1'b1,
                          result_of(0, 64'h55, 0, 0, 64'h148)};
    directed_rows[24] = '{write_item(15, TOP), 1'b1, result_of(1, TOP, 0, 0, 64'h148)};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      push_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 82 : 0;
      recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 19 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_item(random_item(), 1'b0, '0);
      in_valid <= 1'b0;
      // sender holds off until the block has drained
      while (expected_results.size() != 0) @(posedge clk);
    end

    repeat (100) @(posedge clk);
    while (expected_results.size() != 0) begin
      report_mismatch("missing item, result_value", 'x,
                      expected_results.pop_front().result_value);
    end

    $display("Ran %0d items, %0d writes, %0d rejected, ops %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             items_sent, write_count, reject_count, op_count[0], op_count[1], op_count[2],
             op_count[3], op_count[4], op_count[5], op_count[6]);
    $display("Checked %0d results over three idling phases, %0d mismatches", results_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
